@@ rtl/i2cm_pkg.sv @@
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

	// Configuration port
	localparam int unsigned AddrW = 2;
	localparam int unsigned DataW = 32;
	localparam logic [AddrW-1:0] RegPhaseTicks = 2'd0;
	localparam logic [15:0] PhaseTicksReset = 16'd200;

	// Command codes
	localparam logic [2:0] CmdNone  = 3'd0;
	localparam logic [2:0] CmdStart = 3'd1;
	localparam logic [2:0] CmdStop  = 3'd2;
	localparam logic [2:0] CmdWrite = 3'd3;
	localparam logic [2:0] CmdRead  = 3'd4;

	// One tick word as taken from the input channel
	typedef struct packed {
		logic [2:0] command;
		logic [7:0] write_data;
		logic       ack_to_send;
		logic       sda_sample;
	} item_t;

	// One result word as shown on the output channel
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_received;
	} res_t;

endpackage

@@ rtl/i2cm_regs.sv @@
// APB-style configuration register holding the phase length.
module i2cm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [i2cm_pkg::AddrW-1:0]  paddr,
	input  logic [i2cm_pkg::DataW-1:0]  pwdata,
	output logic [i2cm_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output logic [15:0]                 phase_ticks
);

	logic [15:0] phase_ticks_q;
	logic        wr_en;

	assign wr_en = psel & penable & pwrite & (paddr == i2cm_pkg::RegPhaseTicks);

	// Capture the phase length on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cm_pkg::PhaseTicksReset;
		end else if (wr_en) begin
			phase_ticks_q <= pwdata[15:0];
		end
	end

	// Read back the register, zero elsewhere
	always_comb begin
		prdata = '0;
		if (paddr == i2cm_pkg::RegPhaseTicks) begin
			prdata = {{(i2cm_pkg::DataW-16){1'b0}}, phase_ticks_q};
		end
	end

	assign pready      = 1'b1;
	assign phase_ticks = phase_ticks_q;

endmodule

@@ rtl/i2cm_seq.sv @@
// Bus phase sequencer: advances SCL/SDA phases by one tick per word.
module i2cm_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  i2cm_pkg::item_t item,
	input  logic [15:0]     phase_ticks,
	output i2cm_pkg::res_t  res
);

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST_A, PH_ST_B, PH_ST_C,
		PH_SP_A, PH_SP_B, PH_SP_C,
		PH_W_SET, PH_W_HIGH, PH_W_LOW,
		PH_WA_LOW, PH_WA_HIGH,
		PH_R_LOW, PH_R_HIGH,
		PH_K_REL, PH_K_SET, PH_K_HIGH, PH_K_LOW
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] tick_q, tick_d;
	logic        ack_q, ack_d;
	logic [7:0]  rbyte_q, rbyte_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        acks_q, acks_d;
	logic        done;
	logic        rel;
	logic [15:0] limit;
	logic [15:0] tick_inc;
	logic [3:0]  bit_inc;
	logic [7:0]  shl_w;
	logic [7:0]  shl_r;

	assign limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
	assign tick_inc = tick_q + 16'd1;
	assign bit_inc  = bit_q + 4'd1;
	assign shl_w    = {shift_q[6:0], 1'b0};
	assign shl_r    = {shift_q[6:0], item.sda_sample};

	// Work out the state after this tick
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		tick_d  = tick_q;
		ack_d   = ack_q;
		rbyte_d = rbyte_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		acks_d  = acks_q;
		done    = 1'b0;
		if (phase_q == PH_IDLE) begin
			// Take a command, or hold
			case (item.command)
				i2cm_pkg::CmdStart: begin
					phase_d = PH_ST_A; scl_d = 1'b1; sda_d = 1'b1; tick_d = '0;
				end
				i2cm_pkg::CmdStop: begin
					phase_d = PH_SP_A; scl_d = 1'b0; sda_d = 1'b0; tick_d = '0;
				end
				i2cm_pkg::CmdWrite: begin
					shift_d = item.write_data;
					bit_d   = '0;
					phase_d = PH_W_SET; scl_d = 1'b0; sda_d = item.write_data[7];
					tick_d  = '0;
				end
				i2cm_pkg::CmdRead: begin
					shift_d = '0;
					bit_d   = '0;
					acks_d  = item.ack_to_send;
					phase_d = PH_R_LOW; scl_d = 1'b0; sda_d = 1'b1; tick_d = '0;
				end
				default: begin
				end
			endcase
		end else begin
			tick_d = tick_inc;
			if (tick_inc >= limit) begin
				// End of phase: enter the next one
				tick_d = '0;
				case (phase_q)
					PH_ST_A:   begin phase_d = PH_ST_B; scl_d = 1'b1; sda_d = 1'b0; end
					PH_ST_B:   begin phase_d = PH_ST_C; scl_d = 1'b0; sda_d = 1'b0; end
					PH_SP_A:   begin phase_d = PH_SP_B; scl_d = 1'b1; sda_d = 1'b0; end
					PH_SP_B:   begin phase_d = PH_SP_C; scl_d = 1'b1; sda_d = 1'b1; end
					PH_W_SET:  begin phase_d = PH_W_HIGH; scl_d = 1'b1; sda_d = shift_q[7]; end
					PH_W_HIGH: begin phase_d = PH_W_LOW; scl_d = 1'b0; sda_d = shift_q[7]; end
					PH_W_LOW: begin
						shift_d = shl_w;
						bit_d   = bit_inc;
						scl_d   = 1'b0;
						if (bit_inc >= 4'd8) begin
							phase_d = PH_WA_LOW; sda_d = 1'b1;
						end else begin
							phase_d = PH_W_SET; sda_d = shl_w[7];
						end
					end
					PH_WA_LOW: begin phase_d = PH_WA_HIGH; scl_d = 1'b1; sda_d = 1'b1; end
					PH_WA_HIGH: begin
						// Sample the acknowledge at the end of SCL high
						ack_d   = ~item.sda_sample;
						phase_d = PH_IDLE; scl_d = 1'b0; sda_d = 1'b0;
						done    = 1'b1;
					end
					PH_R_LOW: begin phase_d = PH_R_HIGH; scl_d = 1'b1; sda_d = 1'b1; end
					PH_R_HIGH: begin
						shift_d = shl_r;
						bit_d   = bit_inc;
						scl_d   = 1'b0;
						sda_d   = 1'b1;
						if (bit_inc >= 4'd8) begin
							rbyte_d = shl_r;
							phase_d = PH_K_REL;
						end else begin
							phase_d = PH_R_LOW;
						end
					end
					PH_K_REL:  begin phase_d = PH_K_SET; scl_d = 1'b0; sda_d = ~acks_q; end
					PH_K_SET:  begin phase_d = PH_K_HIGH; scl_d = 1'b1; sda_d = ~acks_q; end
					PH_K_HIGH: begin phase_d = PH_K_LOW; scl_d = 1'b0; sda_d = ~acks_q; end
					PH_K_LOW, PH_ST_C, PH_SP_C: begin
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// Hold the sequencer state; advance only when a tick word is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			tick_q  <= '0;
			ack_q   <= 1'b0;
			rbyte_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			acks_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			tick_q  <= tick_d;
			ack_q   <= ack_d;
			rbyte_q <= rbyte_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			acks_q  <= acks_d;
		end
	end

	// Result word shows the state after this tick
	assign rel = (phase_d == PH_WA_LOW) || (phase_d == PH_WA_HIGH) ||
		(phase_d == PH_R_LOW) || (phase_d == PH_R_HIGH) || (phase_d == PH_K_REL);

	always_comb begin
		res.scl_level    = scl_d;
		res.sda_level    = rel ? 1'b1 : sda_d;
		res.sda_enable   = ~rel;
		res.busy_res     = (phase_d != PH_IDLE);
		res.done_res     = done;
		res.read_data    = rbyte_d;
		res.ack_received = ack_d;
	end

endmodule

@@ rtl/i2c_master_byte_engine.sv @@
// Tick words wait in the input register, result words in the result register.
// Throughput: one tick word per cycle; the input register, the phase sequencer
// and the result register each pass one word per cycle while not stalled.
// Reset: arst_n clears both stages and puts the bus lines released (SCL and SDA
// high), the sequencer idle and the phase length at 200 ticks.
module i2c_master_byte_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  command,
	input  logic [7:0]                  write_data,
	input  logic                        ack_to_send,
	input  logic                        sda_sample,
	// output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        scl_level,
	output logic                        sda_level,
	output logic                        sda_enable,
	output logic                        busy_res,
	output logic                        done_res,
	output logic [7:0]                  read_data,
	output logic                        ack_received,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [i2cm_pkg::AddrW-1:0]  paddr,
	input  logic [i2cm_pkg::DataW-1:0]  pwdata,
	output logic [i2cm_pkg::DataW-1:0]  prdata,
	output logic                        pready
);

	logic            valid_s1;
	i2cm_pkg::item_t item_s1;
	logic            out_valid_q;
	i2cm_pkg::res_t  res_q;
	i2cm_pkg::res_t  res_next;
	logic [15:0]     phase_ticks;
	logic            fire;
	logic            in_take;

	assign fire     = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | fire;
	assign in_take  = in_valid & in_ready;

	i2cm_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.phase_ticks (phase_ticks)
	);

	// Input stage: hold a word until the sequencer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take | (valid_s1 & ~fire);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.command     <= command;
			item_s1.write_data  <= write_data;
			item_s1.ack_to_send <= ack_to_send;
			item_s1.sda_sample  <= sda_sample;
		end
	end

	i2cm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.phase_ticks (phase_ticks),
		.res         (res_next)
	);

	// Result register: hold the word until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= fire | (out_valid_q & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign scl_level    = res_q.scl_level;
	assign sda_level    = res_q.sda_level;
	assign sda_enable   = res_q.sda_enable;
	assign busy_res     = res_q.busy_res;
	assign done_res     = res_q.done_res;
	assign read_data    = res_q.read_data;
	assign ack_received = res_q.ack_received;

endmodule

@@ rtl/i2cm_checker.sv @@
// Port-level checks for the I2C master byte engine, bound to the top level.
module i2cm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        scl_level,
	input logic                        sda_level,
	input logic                        sda_enable,
	input logic                        busy_res,
	input logic                        done_res,
	input logic [7:0]                  read_data,
	input logic                        ack_received,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [i2cm_pkg::AddrW-1:0]  paddr,
	input logic [i2cm_pkg::DataW-1:0]  pwdata,
	input logic [i2cm_pkg::DataW-1:0]  prdata
);

	// A finished command leaves the engine idle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done_res while busy_res");

	// A released SDA always reads as high
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sda_enable |-> sda_level)
		else $error("sda released but level low");

	// A stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({scl_level, sda_level, sda_enable, busy_res, done_res,
				read_data, ack_received}))
		else $error("result word changed while stalled");

	// A phase length write reads back
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr == i2cm_pkg::RegPhaseTicks) |=>
			(paddr != i2cm_pkg::RegPhaseTicks) || (prdata[15:0] == $past(pwdata[15:0])))
		else $error("phase_ticks readback mismatch");

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.scl_level    (scl_level),
	.sda_level    (sda_level),
	.sda_enable   (sda_enable),
	.busy_res     (busy_res),
	.done_res     (done_res),
	.read_data    (read_data),
	.ack_received (ack_received),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);

@@ bench/tb_top.sv @@
// Self-checking bench for the I2C master byte engine: tick stimulus, bus predictor, word checks.
module tb_top;

	// Command codes the engine must ignore
	localparam logic [2:0] CmdUnusedLo = 3'd5;
	localparam logic [2:0] CmdUnusedHi = 3'd7;

	// Phases of the bus sequencer as tracked by the predictor
	typedef enum logic [4:0] {
		PhIdle, PhStartA, PhStartB, PhStartC, PhStopA, PhStopB, PhStopC,
		PhWrSet, PhWrHigh, PhWrLow, PhWrAckLow, PhWrAckHigh,
		PhRdLow, PhRdHigh, PhAckRel, PhAckSet, PhAckHigh, PhAckLow
	} seq_phase_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  command = i2cm_pkg::CmdNone;
	logic [7:0]  write_data = 8'd0;
	logic        ack_to_send = 1'b0;
	logic        sda_sample = 1'b1;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        scl_level;
	logic        sda_level;
	logic        sda_enable;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_data;
	logic        ack_received;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [i2cm_pkg::AddrW-1:0] paddr = i2cm_pkg::RegPhaseTicks;
	logic [i2cm_pkg::DataW-1:0] pwdata = '0;
	logic [i2cm_pkg::DataW-1:0] prdata;
	logic        pready;

	// Predictor state
	logic [15:0] cfg_ticks = i2cm_pkg::PhaseTicksReset;
	seq_phase_e  ph = PhIdle;
	logic [3:0]  bit_idx = 4'd0;
	logic [7:0]  shreg = 8'd0;
	logic [15:0] tcount = 16'd0;
	logic        ack_seen = 1'b0;
	logic [7:0]  rd_byte = 8'd0;
	logic        scl_q = 1'b1;
	logic        sda_q = 1'b1;
	logic        ack_tx = 1'b0;

	// Stimulus and scoreboard
	i2cm_pkg::item_t tick_q[$];
	i2cm_pkg::res_t  exp_bus_q[$];
	int unsigned ticks_queued = 0;
	int unsigned ticks_taken = 0;
	int unsigned err_cnt = 0;
	bit          gaps_on = 1'b1;
	int unsigned send_gap = 0;
	int unsigned rcv_stall = 0;
	logic        nxt_valid;
	logic        nxt_ready;
	i2cm_pkg::item_t cur_tick;
	i2cm_pkg::item_t nxt_tick;
	i2cm_pkg::res_t  exp_word;
	i2cm_pkg::res_t  got_word;

	i2c_master_byte_engine dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Enter a phase with its line levels and restart the tick count
	task automatic go_phase(input seq_phase_e p, input logic c, input logic d);
		ph = p;
		scl_q = c;
		sda_q = d;
		tcount = 16'd0;
	endtask

	// Advance the bus sequencer by one tick and form the word it shows
	task automatic bus_tick(input i2cm_pkg::item_t it, output i2cm_pkg::res_t r);
		logic [15:0] lim;
		logic        fin;
		logic        rel;
		lim = (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
		fin = 1'b0;
		if (ph == PhIdle) begin
			case (it.command)
				i2cm_pkg::CmdStart: go_phase(PhStartA, 1'b1, 1'b1);
				i2cm_pkg::CmdStop:  go_phase(PhStopA, 1'b0, 1'b0);
				i2cm_pkg::CmdWrite: begin
					shreg = it.write_data;
					bit_idx = 4'd0;
					go_phase(PhWrSet, 1'b0, shreg[7]);
				end
				i2cm_pkg::CmdRead: begin
					shreg = 8'd0;
					bit_idx = 4'd0;
					ack_tx = it.ack_to_send;
					go_phase(PhRdLow, 1'b0, 1'b1);
				end
				default: ;
			endcase
		end else begin
			tcount = tcount + 16'd1;
			if (tcount >= lim) begin
				case (ph)
					PhStartA: go_phase(PhStartB, 1'b1, 1'b0);
					PhStartB: go_phase(PhStartC, 1'b0, 1'b0);
					PhStopA:  go_phase(PhStopB, 1'b1, 1'b0);
					PhStopB:  go_phase(PhStopC, 1'b1, 1'b1);
					PhWrSet:  go_phase(PhWrHigh, 1'b1, shreg[7]);
					PhWrHigh: go_phase(PhWrLow, 1'b0, shreg[7]);
					PhWrLow: begin
						shreg = {shreg[6:0], 1'b0};
						bit_idx = bit_idx + 4'd1;
						if (bit_idx >= 4'd8) go_phase(PhWrAckLow, 1'b0, 1'b1);
						else go_phase(PhWrSet, 1'b0, shreg[7]);
					end
					PhWrAckLow: go_phase(PhWrAckHigh, 1'b1, 1'b1);
					PhWrAckHigh: begin
						// slave acknowledges by holding SDA low
						ack_seen = ~it.sda_sample;
						go_phase(PhIdle, 1'b0, 1'b0);
						fin = 1'b1;
					end
					PhRdLow: go_phase(PhRdHigh, 1'b1, 1'b1);
					PhRdHigh: begin
						shreg = {shreg[6:0], it.sda_sample};
						bit_idx = bit_idx + 4'd1;
						if (bit_idx >= 4'd8) begin
							rd_byte = shreg;
							go_phase(PhAckRel, 1'b0, 1'b1);
						end else begin
							go_phase(PhRdLow, 1'b0, 1'b1);
						end
					end
					PhAckRel:  go_phase(PhAckSet, 1'b0, ~ack_tx);
					PhAckSet:  go_phase(PhAckHigh, 1'b1, ~ack_tx);
					PhAckHigh: go_phase(PhAckLow, 1'b0, ~ack_tx);
					PhAckLow, PhStartC, PhStopC: begin
						go_phase(PhIdle, scl_q, sda_q);
						fin = 1'b1;
					end
					default: go_phase(PhIdle, scl_q, sda_q);
				endcase
			end
		end
		rel = ph inside {PhWrAckLow, PhWrAckHigh, PhRdLow, PhRdHigh, PhAckRel};
		r.scl_level = scl_q;
		r.sda_level = rel ? 1'b1 : sda_q;
		r.sda_enable = ~rel;
		r.busy_res = (ph != PhIdle);
		r.done_res = fin;
		r.read_data = rd_byte;
		r.ack_received = ack_seen;
	endtask

	// Driver: present one tick word at a time, predict it on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nxt_valid = in_valid;
			if (in_valid && in_ready) begin
				cur_tick.command = command;
				cur_tick.write_data = write_data;
				cur_tick.ack_to_send = ack_to_send;
				cur_tick.sda_sample = sda_sample;
				bus_tick(cur_tick, exp_word);
				exp_bus_q.push_back(exp_word);
				ticks_taken++;
				nxt_valid = 1'b0;
				send_gap = gaps_on ? $urandom_range(0, 5) : 0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (tick_q.size() > 0) begin
					nxt_tick = tick_q.pop_front();
					command <= nxt_tick.command;
					write_data <= nxt_tick.write_data;
					ack_to_send <= nxt_tick.ack_to_send;
					sda_sample <= nxt_tick.sda_sample;
					nxt_valid = 1'b1;
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// Monitor: take result words with random stalls, compare with the oldest expectation
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got_word.scl_level = scl_level;
				got_word.sda_level = sda_level;
				got_word.sda_enable = sda_enable;
				got_word.busy_res = busy_res;
				got_word.done_res = done_res;
				got_word.read_data = read_data;
				got_word.ack_received = ack_received;
				if (exp_bus_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %0h", $time, got_word);
					err_cnt++;
				end else begin
					exp_word = exp_bus_q.pop_front();
					if (exp_word !== got_word) begin
						$display("%0t: result word mismatch, expected %0h, actual %0h",
							$time, exp_word, got_word);
						err_cnt++;
					end
				end
				rcv_stall = gaps_on ? $urandom_range(0, 5) : 0;
			end
			if (rcv_stall > 0) begin
				rcv_stall--;
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
			out_ready <= nxt_ready;
		end
	end

	task automatic push_tick(input logic [2:0] c, input logic [7:0] d, input logic a,
		input logic s);
		i2cm_pkg::item_t it;
		it.command = c;
		it.write_data = d;
		it.ack_to_send = a;
		it.sda_sample = s;
		tick_q.push_back(it);
		ticks_queued++;
	endtask

	task automatic push_idle(input int unsigned n, input logic s);
		for (int unsigned i = 0; i < n; i++) push_tick(i2cm_pkg::CmdNone, 8'd0, 1'b0, s);
	endtask

	// Mostly plain ticks; commands land whenever the sequencer happens to be idle
	task automatic push_random(input int unsigned n);
		int unsigned pick;
		logic [2:0]  c;
		for (int unsigned i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) c = i2cm_pkg::CmdNone;
			else if (pick < 95) c = 3'($urandom_range(i2cm_pkg::CmdStart, i2cm_pkg::CmdRead));
			else c = 3'($urandom_range(CmdUnusedLo, CmdUnusedHi));
			push_tick(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end
	endtask

	// Hold until every queued word is taken and every expected word has arrived
	task automatic settle();
		int unsigned n;
		n = 0;
		while ((ticks_taken != ticks_queued || exp_bus_q.size() != 0) && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (ticks_taken != ticks_queued || exp_bus_q.size() != 0) begin
			$display("%0t: words left over, expected 0, actual %0d", $time,
				exp_bus_q.size() + ticks_queued - ticks_taken);
			err_cnt++;
		end
		repeat (4) @(posedge clk);
	endtask

	// Write the phase length through the configuration port
	task automatic set_ticks(input logic [15:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= i2cm_pkg::RegPhaseTicks;
		pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cfg_ticks = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset phase length, ignored codes, command while busy
		push_tick(i2cm_pkg::CmdNone, 8'd0, 1'b0, 1'b1);
		push_tick(CmdUnusedLo, 8'h5a, 1'b1, 1'b0);
		push_tick(CmdUnusedHi, 8'ha5, 1'b0, 1'b1);
		push_tick(i2cm_pkg::CmdStart, 8'd0, 1'b0, 1'b1);
		push_tick(i2cm_pkg::CmdWrite, 8'hff, 1'b1, 1'b0);
		push_idle(3, 1'b1);
		settle();

		// zero length acts as one tick; write with NACK, read zeros and send NACK
		set_ticks(16'd0);
		push_tick(i2cm_pkg::CmdStart, 8'd0, 1'b0, 1'b1);
		push_idle(4, 1'b1);
		push_tick(i2cm_pkg::CmdWrite, 8'h00, 1'b0, 1'b1);
		push_idle(28, 1'b1);
		push_tick(i2cm_pkg::CmdRead, 8'h00, 1'b0, 1'b0);
		push_idle(32, 1'b0);
		settle();

		// back to back: write with ACK, read ones and send ACK, stop
		set_ticks(16'd1);
		gaps_on = 1'b0;
		push_tick(i2cm_pkg::CmdWrite, 8'hff, 1'b1, 1'b0);
		push_idle(28, 1'b0);
		push_tick(i2cm_pkg::CmdRead, 8'hff, 1'b1, 1'b1);
		push_idle(32, 1'b1);
		push_tick(i2cm_pkg::CmdStop, 8'd0, 1'b0, 1'b0);
		push_idle(4, 1'b0);
		settle();

		// longest phase: start stays in its first phase
		set_ticks(16'hffff);
		gaps_on = 1'b1;
		push_tick(i2cm_pkg::CmdStart, 8'd0, 1'b0, 1'b1);
		push_idle(6, 1'b1);
		settle();

		// random ticks at short phase lengths
		set_ticks(16'd1);
		push_random(175);
		settle();
		set_ticks(16'd2);
		gaps_on = 1'b0;
		push_random(125);
		settle();
		set_ticks(16'd3);
		gaps_on = 1'b1;
		push_random(100);
		settle();
		set_ticks(16'($urandom_range(4, 5)));
		push_random(50);
		settle();

		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
